/* design/nse_pkg.sv */
package nse_pkg;

    localparam int RECORD_DEPTH_DEF = 64;
    localparam int NAME_LENGTH      = 5;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic       OP_RX   = 1'b0;
    localparam logic       OP_READ = 1'b1;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_GGA  = 3'd1;
    localparam logic [2:0] KIND_GSA  = 3'd2;
    localparam logic [2:0] KIND_GSV  = 3'd3;
    localparam logic [2:0] KIND_RMC  = 3'd4;
    localparam logic [2:0] KIND_VTG  = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [5:0] read_index;
    } nse_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] sentence_kind;
        logic       sentence_done;
        logic       field_truncated;
    } nse_out_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_NAME,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_READ,
        CMD_WRITE,
        CMD_PAD
    } cmd_kind_t;

    // one request handed from the front to the back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] addr;
        logic [7:0] data;
        logic [3:0] pad_count;
        logic       done;
        logic       trunc;
        logic [2:0] skind;
    } nse_cmd_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] pos;
        logic [3:0] width;
    } field_info_t;

    function automatic field_info_t field_lookup(input logic [2:0] kind,
                                                 input logic [3:0] field);
        field_info_t r;
        r = '{hit: 1'b0, pos: 8'd0, width: 4'd0};
        unique case ({kind, field})
            {KIND_GGA, 4'd6}: r = '{1'b1, 8'd0, 4'd1};
            {KIND_GGA, 4'd7}: r = '{1'b1, 8'd1, 4'd2};
            {KIND_GSV, 4'd3}: r = '{1'b1, 8'd3, 4'd2};
            {KIND_RMC, 4'd1}: r = '{1'b1, 8'd28, 4'd6};
            {KIND_RMC, 4'd2}: r = '{1'b1, 8'd5, 4'd1};
            {KIND_RMC, 4'd3}: r = '{1'b1, 8'd6, 4'd10};
            {KIND_RMC, 4'd4}: r = '{1'b1, 8'd16, 4'd1};
            {KIND_RMC, 4'd5}: r = '{1'b1, 8'd17, 4'd10};
            {KIND_RMC, 4'd6}: r = '{1'b1, 8'd27, 4'd1};
            {KIND_RMC, 4'd9}: r = '{1'b1, 8'd34, 4'd6};
            {KIND_VTG, 4'd3}: r = '{1'b1, 8'd40, 4'd5};
            {KIND_VTG, 4'd4}: r = '{1'b1, 8'd45, 4'd6};
            default:          r = '{1'b0, 8'd0, 4'd0};
        endcase
        return r;
    endfunction

    function automatic logic [3:0] last_field(input logic [2:0] kind);
        logic [3:0] r;
        unique case (kind)
            KIND_GGA: r = 4'd7;
            KIND_GSV: r = 4'd3;
            KIND_RMC: r = 4'd9;
            KIND_VTG: r = 4'd4;
            default:  r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

/* design/nse_front.sv */
module nse_front
    import nse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  nse_in_t  in_data,
    output logic     cmd_valid,
    input  logic     cmd_stall,
    output nse_cmd_t cmd
);

    phase_t     phase_reg, phase_next;
    logic [2:0] type_reg, type_next;
    logic [7:0] name_reg [NAME_LENGTH-1];
    logic [2:0] ncount_reg, ncount_next;
    logic [3:0] comma_reg, comma_next;
    logic [3:0] fidx_reg, fidx_next;

    field_info_t fi;
    logic        name_last;
    logic [2:0]  hit;
    logic [7:0]  c;

    assign in_stall  = cmd_stall;
    assign cmd_valid = in_valid;
    assign c         = in_data.rx_byte;
    assign fi        = field_lookup(type_reg, comma_reg);
    assign name_last = (ncount_reg == 3'(NAME_LENGTH - 1));

    always_comb
    begin
        priority if ({name_reg[0], name_reg[1], name_reg[2], name_reg[3], c} == "GPGGA")
            hit = KIND_GGA;
        else if ({name_reg[0], name_reg[1], name_reg[2], name_reg[3], c} == "GPGSA")
            hit = KIND_GSA;
        else if ({name_reg[0], name_reg[1], name_reg[2], name_reg[3], c} == "GPGSV")
            hit = KIND_GSV;
        else if ({name_reg[0], name_reg[1], name_reg[2], name_reg[3], c} == "GPRMC")
            hit = KIND_RMC;
        else if ({name_reg[0], name_reg[1], name_reg[2], name_reg[3], c} == "GPVTG")
            hit = KIND_VTG;
        else
            hit = KIND_NONE;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        ncount_next = ncount_reg;
        comma_next  = comma_reg;
        fidx_next   = fidx_reg;
        cmd         = '{kind: CMD_NONE, addr: 8'd0, data: 8'd0, pad_count: 4'd0,
                        done: 1'b0, trunc: 1'b0, skind: type_reg};
        priority if (in_data.opcode == OP_READ)
        begin
            cmd.kind = CMD_READ;
            cmd.addr = {2'b00, in_data.read_index};
        end
        else if (c == CH_DOLLAR)
        begin
            phase_next  = PH_NAME;
            ncount_next = 3'd0;
        end
        else if (phase_reg == PH_NAME)
        begin
            ncount_next = ncount_reg + 3'd1;
            if (name_last)
            begin
                if (hit != KIND_NONE)
                    type_next = hit;
                if (hit == KIND_NONE || last_field(hit) == 4'd0)
                    phase_next = PH_WAIT;
                else
                begin
                    phase_next = PH_BODY;
                    comma_next = 4'd0;
                    fidx_next  = 4'd0;
                end
            end
        end
        else if (phase_reg == PH_BODY)
        begin
            if (c == CH_COMMA)
            begin
                if (fi.hit)
                begin
                    if (fidx_reg < fi.width)
                    begin
                        cmd.kind      = CMD_PAD;
                        cmd.addr      = fi.pos + 8'(fidx_reg);
                        cmd.pad_count = fi.width - fidx_reg;
                    end
                    if (comma_reg == last_field(type_reg))
                    begin
                        cmd.done   = 1'b1;
                        phase_next = PH_WAIT;
                    end
                end
                if (comma_reg != 4'd15)
                    comma_next = comma_reg + 4'd1;
                fidx_next = 4'd0;
            end
            else if (fi.hit)
            begin
                if (fidx_reg < fi.width)
                begin
                    cmd.kind  = CMD_WRITE;
                    cmd.addr  = fi.pos + 8'(fidx_reg);
                    cmd.data  = c;
                    fidx_next = fidx_reg + 4'd1;
                end
                else
                    cmd.trunc = 1'b1;
            end
        end
        else
            phase_next = PH_WAIT;
        cmd.skind = type_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            type_reg   <= KIND_NONE;
            ncount_reg <= 3'd0;
            comma_reg  <= 4'd0;
            fidx_reg   <= 4'd0;
            for (int i = 0; i < NAME_LENGTH - 1; i++)
                name_reg[i] <= 8'd0;
        end
        else if (in_valid && !in_stall)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            ncount_reg <= ncount_next;
            comma_reg  <= comma_next;
            fidx_reg   <= fidx_next;
            if (in_data.opcode == OP_RX && c != CH_DOLLAR && phase_reg == PH_NAME
                && ncount_reg < 3'(NAME_LENGTH - 1))
                name_reg[ncount_reg[1:0]] <= c;
        end
    end

endmodule

/* design/nse_queue.sv */
module nse_queue
    import nse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_stall,
    input  nse_cmd_t wr_data,
    output logic     rd_valid,
    input  logic     rd_stall,
    output nse_cmd_t rd_data
);

    nse_cmd_t   slot_reg [QUEUE_DEPTH];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign wr_stall = (count_reg == 2'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* design/nse_back.sv */
module nse_back
    import nse_pkg::*;
#(
    parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  nse_cmd_t cmd,
    output logic     out_valid,
    input  logic     out_stall,
    output nse_out_t out_data
);

    localparam int AW = $clog2(RECORD_DEPTH);

    logic [7:0]  mem [RECORD_DEPTH];
    logic [RECORD_DEPTH-1:0] vld_reg;
    logic        busy_reg;
    logic [7:0]  addr_reg;
    logic [3:0]  left_reg;
    nse_out_t    res_reg;
    logic        rd_pend_reg, rd_ok_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [7:0]  rd_q_reg;
    logic        take, in_range_a, in_range_c;

    assign cmd_stall  = busy_reg || (out_valid && out_stall) || rd_pend_reg;
    assign take       = cmd_valid && !cmd_stall;
    assign in_range_a = ({1'b0, addr_reg} < 9'(RECORD_DEPTH));
    assign in_range_c = ({1'b0, cmd.addr} < 9'(RECORD_DEPTH));

    always_ff @(posedge clk)
    begin
        if (busy_reg && in_range_a)
            mem[addr_reg[AW-1:0]] <= CH_ZERO;
        else if (take && cmd.kind == CMD_WRITE && in_range_c)
            mem[cmd.addr[AW-1:0]] <= cmd.data;
        rd_q_reg <= mem[rd_addr_reg];
    end

    always_comb
    begin
        out_data = res_reg;
        if (rd_ok_reg)
            out_data.read_data = vld_reg[rd_addr_reg] ? rd_q_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            busy_reg    <= 1'b0;
            addr_reg    <= 8'd0;
            left_reg    <= 4'd0;
            res_reg     <= '0;
            out_valid   <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            rd_pend_reg <= 1'b0;
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (rd_pend_reg)
                out_valid <= 1'b1;
            if (busy_reg)
            begin
                if (in_range_a)
                    vld_reg[addr_reg[AW-1:0]] <= 1'b1;
                addr_reg <= addr_reg + 8'd1;
                left_reg <= left_reg - 4'd1;
                if (left_reg == 4'd1)
                begin
                    busy_reg  <= 1'b0;
                    out_valid <= 1'b1;
                end
            end
            else if (take)
            begin
                res_reg   <= '{read_data: 8'd0, sentence_kind: cmd.skind,
                               sentence_done: cmd.done, field_truncated: cmd.trunc};
                rd_ok_reg <= 1'b0;
                unique case (cmd.kind)
                    CMD_READ:
                    begin
                        rd_addr_reg <= cmd.addr[AW-1:0];
                        rd_ok_reg   <= in_range_c;
                        rd_pend_reg <= 1'b1;
                    end
                    CMD_PAD:
                    begin
                        busy_reg <= 1'b1;
                        addr_reg <= cmd.addr;
                        left_reg <= cmd.pad_count;
                    end
                    CMD_WRITE:
                    begin
                        if (in_range_c)
                            vld_reg[cmd.addr[AW-1:0]] <= 1'b1;
                        out_valid <= 1'b1;
                    end
                    default:
                        out_valid <= 1'b1;
                endcase
            end
        end
    end

endmodule

/* design/nmea_sentence_field_extractor.sv */
// A field close pads the rest of the field with '0' (up to 10 bytes);
// the record memory writes one padding byte per cycle. The back end
// takes no new request while padding, reading the record or holding a
// stalled result.
// Reset: asynchronous, active low; parser to waiting for '$', record
// reads as zero through per-byte valid flags cleared at reset.
module nmea_sentence_field_extractor
    import nse_pkg::*;
#(
    parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  nse_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output nse_out_t out_data
);

    logic     f_valid, f_stall, q_valid, q_stall;
    nse_cmd_t f_cmd, q_cmd;

    nse_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
    );

    nse_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_cmd)
    );

    nse_back #(.RECORD_DEPTH(RECORD_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd(q_cmd),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

/* design/nse_checker.sv */
module nse_checker
    import nse_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input nse_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input nse_out_t out_data
);

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.sentence_kind <= KIND_VTG)
        else $error("sentence kind out of range");

    a_done_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.sentence_done && out_data.field_truncated))
        else $error("done and truncated together");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled request changed");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind nmea_sentence_field_extractor nse_checker u_nse_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
